@@ hdl/ops_pkg.sv @@
`default_nettype none

package ops_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int KERNEL_W     = 3;
	localparam int LAG_W        = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;
	localparam int NUM_BINS     = 24;
	localparam int BIN_W        = 5;
	localparam int COUNT_W      = 16;
	localparam int SEEN_W       = 17;
	localparam int ELEM_W       = 2;
	localparam int KERNEL_LIMIT = 4;

	localparam int MAX_KERNEL_DEF  = 4;
	localparam int MAX_LAG_DEF     = 64;
	localparam int DELAY_DEPTH_DEF = 256;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LAG           = 1'b1;

	localparam logic [KERNEL_W-1:0] KERNEL_RESET = 3'd3;
	localparam logic [LAG_W-1:0]    LAG_RESET    = 7'd1;

	typedef enum logic {
		KIND_SYMBOL = 1'b0,
		KIND_BIN    = 1'b1
	} kind_t;

	typedef struct packed {
		logic              accept;
		logic              reduce;
		logic              rd_issue;
		logic [ELEM_W-1:0] rd_elem;
		logic              rank_ld;
		logic              hist_rd;
		logic              hist_sel_bin;
		logic              hist_wr;
		logic              emit_sym;
		logic              emit_bin;
		logic [BIN_W-1:0]  bin;
		logic              bin_last;
		logic              clear_rec;
	} cmd_t;

	typedef struct packed {
		logic                full;
		logic                last_rec;
		logic                lag_big;
		logic                out_free;
		logic [KERNEL_W-1:0] k_eff;
	} stat_t;

	// Number of permutations of k elements for k up to 4 (larger k gives 24), which is also the number of bins shown.
	function automatic logic [BIN_W-1:0] fact(input logic [KERNEL_W-1:0] k);
		logic [BIN_W-1:0] f;
		case (k)
			3'd0: f = 5'd1;
			3'd1: f = 5'd1;
			3'd2: f = 5'd2;
			3'd3: f = 5'd6;
			default: f = 5'd24;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

@@ hdl/ordinal_pattern_symbolizer.sv @@
`default_nettype none

// Channel  | Handshake                  | Payload
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
// sample   | sample_valid / sample_stall| sample, last_of_record
// result   | result_valid / result_stall| kind, pattern_index, bin_count, last
//
// A sample that completes no window and ends no record returns to idle after the
// reduce state; a full window reads one delay line element at a time, set by the one
// read port. Lag reduction modulo DELAY_DEPTH runs in the reduce state (none when
// MAX_LAG < DELAY_DEPTH). A record end reads out every histogram bin, one read each.
// Reset clears the record state and sets kernel_length 3, lag 1; a stalled
// result holds the sequencer until the output register frees.

module ordinal_pattern_symbolizer #(
	parameter int MAX_KERNEL  = ops_pkg::MAX_KERNEL_DEF,
	parameter int MAX_LAG     = ops_pkg::MAX_LAG_DEF,
	parameter int DELAY_DEPTH = ops_pkg::DELAY_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [ops_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ops_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 sample_valid,
	output      logic                                 sample_stall,
	input  wire logic signed [ops_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                 last_of_record,
	output      logic                                 result_valid,
	input  wire logic                                 result_stall,
	output      logic                                 kind,
	output      logic [ops_pkg::BIN_W-1:0]            pattern_index,
	output      logic [ops_pkg::COUNT_W-1:0]          bin_count,
	output      logic                                 last
);
	import ops_pkg::*;

	logic [KERNEL_W-1:0] kernel_length_q;
	logic [LAG_W-1:0]    lag_q;
	cmd_t                cmd;
	stat_t               stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_length_q <= KERNEL_RESET;
			lag_q           <= LAG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KERNEL_LENGTH: kernel_length_q <= cfg_data[KERNEL_W-1:0];
				REG_LAG:           lag_q <= cfg_data[LAG_W-1:0];
				default: ;
			endcase
		end
	end

	ops_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	ops_dp #(
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_LAG     (MAX_LAG),
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kernel_length  (kernel_length_q),
		.lag            (lag_q),
		.sample         (sample),
		.last_of_record (last_of_record),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.kind           (kind),
		.pattern_index  (pattern_index),
		.bin_count      (bin_count),
		.last           (last)
	);

endmodule

`default_nettype wire

@@ hdl/ops_dp.sv @@
`default_nettype none

module ops_dp #(
	parameter int MAX_KERNEL  = ops_pkg::MAX_KERNEL_DEF,
	parameter int MAX_LAG     = ops_pkg::MAX_LAG_DEF,
	parameter int DELAY_DEPTH = ops_pkg::DELAY_DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire ops_pkg::cmd_t                         cmd,
	output      ops_pkg::stat_t                        stat,
	input  wire logic [ops_pkg::KERNEL_W-1:0]          kernel_length,
	input  wire logic [ops_pkg::LAG_W-1:0]             lag,
	input  wire logic signed [ops_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                                  last_of_record,
	input  wire logic                                  result_stall,
	output      logic                                  result_valid,
	output      logic                                  kind,
	output      logic [ops_pkg::BIN_W-1:0]             pattern_index,
	output      logic [ops_pkg::COUNT_W-1:0]           bin_count,
	output      logic                                  last
);
	import ops_pkg::*;

	localparam int PTR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
	localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W+1)'(DELAY_DEPTH);

	// Stable ascending sort of the window, then the lexicographic rank of the
	// resulting element order.
	function automatic logic [BIN_W-1:0] ordinal_rank(
		input logic [KERNEL_LIMIT-1:0][SAMPLE_W-1:0] v,
		input logic [KERNEL_W-1:0]                    k
	);
		logic [ELEM_W-1:0] perm [KERNEL_LIMIT];
		logic [2:0]        r;
		logic [2:0]        smaller;
		logic [BIN_W-1:0]  rank;
		for (int i = 0; i < KERNEL_LIMIT; i++) begin
			perm[i] = '0;
		end
		rank = '0;
		for (int i = 0; i < KERNEL_LIMIT; i++) begin
			if (i < 32'(k)) begin
				r = '0;
				for (int j = 0; j < KERNEL_LIMIT; j++) begin
					if (j < 32'(k) && (($signed(v[j]) < $signed(v[i])) ||
							(v[j] == v[i] && j < i))) begin
						r = r + 3'd1;
					end
				end
				perm[r[ELEM_W-1:0]] = ELEM_W'(i);
			end
		end
		for (int i = 0; i < KERNEL_LIMIT; i++) begin
			if (i < 32'(k)) begin
				smaller = '0;
				for (int j = i + 1; j < KERNEL_LIMIT; j++) begin
					if (j < 32'(k) && perm[j] < perm[i]) begin
						smaller = smaller + 3'd1;
					end
				end
				rank = rank + BIN_W'(smaller) * fact(KERNEL_W'(32'(k) - 1 - i));
			end
		end
		return rank;
	endfunction

	// Effective configuration for the item being accepted.
	logic [KERNEL_W-1:0] k_eff;
	logic [LAG_W-1:0]    l_eff;
	logic [LAG_W+1:0]    span;
	logic [SEEN_W-1:0]   seen_next;
	logic [SEEN_W-1:0]   seen_q;

	always_comb begin
		k_eff = kernel_length;
		if (k_eff == '0) begin
			k_eff = KERNEL_W'(1);
		end else if (32'(k_eff) > MAX_KERNEL) begin
			k_eff = KERNEL_W'(MAX_KERNEL);
		end
		l_eff = lag;
		if (l_eff == '0) begin
			l_eff = LAG_W'(1);
		end else if (32'(l_eff) > MAX_LAG) begin
			l_eff = LAG_W'(MAX_LAG);
		end
		span      = (LAG_W+2)'(k_eff - 3'd1) * (LAG_W+2)'(l_eff);
		seen_next = (&seen_q) ? seen_q : seen_q + 1'b1;
	end

	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    addr_q;
	logic [LAG_W-1:0]    lr_q;
	logic [KERNEL_W-1:0] k_q;
	logic                full_q;
	logic                last_rec_q;
	logic                rd_en_s1;
	logic [ELEM_W-1:0]   rd_elem_s1;
	logic [NUM_BINS-1:0] hist_vld_q;
	logic                out_valid_q;
	logic [BIN_W-1:0]    rank_q;

	logic [PTR_W-1:0] wr_ptr_next;
	logic [PTR_W-1:0] lr_ptr;
	logic [PTR_W-1:0] addr_prev;
	logic             lag_big;
	logic             out_free;

	assign wr_ptr_next = (32'(wr_ptr_q) == DELAY_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
	assign lr_ptr      = PTR_W'(lr_q);
	// Step back one lag through the circular line; lr_q is below the depth here.
	assign addr_prev   = (addr_q >= lr_ptr) ? addr_q - lr_ptr :
		PTR_W'(DEPTH_EXT + {1'b0, addr_q} - {1'b0, lr_ptr});
	assign lag_big     = 32'(lr_q) >= DELAY_DEPTH;
	assign out_free    = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			wr_ptr_q    <= '0;
			k_q         <= KERNEL_RESET;
			full_q      <= 1'b0;
			last_rec_q  <= 1'b0;
			rd_en_s1    <= 1'b0;
			rd_elem_s1  <= '0;
			hist_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_en_s1   <= cmd.rd_issue;
			rd_elem_s1 <= cmd.rd_elem;
			if (cmd.accept) begin
				seen_q     <= seen_next;
				wr_ptr_q   <= wr_ptr_next;
				k_q        <= k_eff;
				full_q     <= seen_next > SEEN_W'(span);
				last_rec_q <= last_of_record;
			end
			if (cmd.hist_wr) begin
				hist_vld_q[rank_q] <= 1'b1;
			end
			if (cmd.clear_rec) begin
				hist_vld_q <= '0;
				seen_q     <= '0;
			end
			if (cmd.emit_sym || cmd.emit_bin) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Delay line and window capture.
	logic signed [SAMPLE_W-1:0]              delay_mem [DELAY_DEPTH];
	logic [SAMPLE_W-1:0]                     rd_data_s1;
	logic [KERNEL_LIMIT-1:0][SAMPLE_W-1:0]   win_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			delay_mem[wr_ptr_q] <= sample;
			addr_q              <= wr_ptr_q;
			lr_q                <= l_eff;
		end
		if (cmd.reduce) begin
			lr_q <= lr_q - LAG_W'(DELAY_DEPTH);
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= delay_mem[addr_q];
			addr_q     <= addr_prev;
		end
		if (rd_en_s1) begin
			win_q[rd_elem_s1] <= rd_data_s1;
		end
		if (cmd.rank_ld) begin
			rank_q <= ordinal_rank(win_q, k_q);
		end
	end

	// Histogram: one read port, one write port; an entry not yet written reads as zero.
	logic [COUNT_W-1:0] hist_mem [NUM_BINS];
	logic [COUNT_W-1:0] hist_rd_q;
	logic               hist_rd_vld_q;
	logic [BIN_W-1:0]   hist_addr;
	logic [COUNT_W-1:0] hist_cnt;
	logic [COUNT_W-1:0] hist_inc;

	assign hist_addr = cmd.hist_sel_bin ? cmd.bin : rank_q;
	assign hist_cnt  = hist_rd_vld_q ? hist_rd_q : '0;
	assign hist_inc  = (&hist_cnt) ? hist_cnt : hist_cnt + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.hist_rd) begin
			hist_rd_q     <= hist_mem[hist_addr];
			hist_rd_vld_q <= hist_vld_q[hist_addr];
		end
		if (cmd.hist_wr) begin
			hist_mem[rank_q] <= hist_inc;
		end
	end

	// Output register.
	kind_t              kind_q;
	logic [BIN_W-1:0]   index_q;
	logic [COUNT_W-1:0] count_q;
	logic               last_q;

	always_ff @(posedge clk) begin
		if (cmd.emit_sym) begin
			kind_q  <= KIND_SYMBOL;
			index_q <= rank_q;
			count_q <= '0;
			last_q  <= 1'b0;
		end else if (cmd.emit_bin) begin
			kind_q  <= KIND_BIN;
			index_q <= cmd.bin;
			count_q <= hist_cnt;
			last_q  <= cmd.bin_last;
		end
	end

	assign result_valid  = out_valid_q;
	assign kind          = kind_q;
	assign pattern_index = index_q;
	assign bin_count     = count_q;
	assign last          = last_q;

	assign stat.full     = full_q;
	assign stat.last_rec = last_rec_q;
	assign stat.lag_big  = lag_big;
	assign stat.out_free = out_free;
	assign stat.k_eff    = k_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sym || cmd.emit_bin) |-> out_free)
		else $error("result loaded while the output register is held");

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_sym && cmd.emit_bin))
		else $error("symbol and bin loaded in the same cycle");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_rec |=> (hist_vld_q == '0 && seen_q == '0))
		else $error("record state not cleared");

	a_lag_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> !lag_big)
		else $error("delay line read with an unreduced lag");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |=> rd_en_s1)
		else $error("window read not captured");

endmodule

`default_nettype wire

@@ hdl/ops_ctrl.sv @@
`default_nettype none

module ops_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            sample_valid,
	output      logic            sample_stall,
	input  wire ops_pkg::stat_t  stat,
	output      ops_pkg::cmd_t   cmd
);
	import ops_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_WAIT,
		ST_RANK,
		ST_HREAD,
		ST_HWRITE,
		ST_FREAD,
		ST_FEMIT
	} state_t;

	state_t            state_q;
	logic [ELEM_W-1:0] elem_q;
	logic [BIN_W-1:0]  bin_q;

	logic             accept;
	logic [BIN_W-1:0] nb;
	logic             bin_last;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign nb           = fact(stat.k_eff);
	assign bin_last     = (bin_q == nb - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_q  <= '0;
			bin_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (!stat.lag_big) begin
						if (stat.full) begin
							elem_q  <= ELEM_W'(stat.k_eff - 3'd1);
							state_q <= ST_READ;
						end else if (stat.last_rec) begin
							bin_q   <= '0;
							state_q <= ST_FREAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					if (elem_q == '0) begin
						state_q <= ST_WAIT;
					end else begin
						elem_q <= elem_q - 1'b1;
					end
				end
				ST_WAIT:  state_q <= ST_RANK;
				ST_RANK:  state_q <= ST_HREAD;
				ST_HREAD: state_q <= ST_HWRITE;
				ST_HWRITE: begin
					if (stat.out_free) begin
						if (stat.last_rec) begin
							bin_q   <= '0;
							state_q <= ST_FREAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FREAD: state_q <= ST_FEMIT;
				ST_FEMIT: begin
					if (stat.out_free) begin
						if (bin_last) begin
							state_q <= ST_IDLE;
						end else begin
							bin_q   <= bin_q + 1'b1;
							state_q <= ST_FREAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_elem  = elem_q;
		cmd.bin      = bin_q;
		cmd.bin_last = bin_last;
		case (state_q)
			ST_IDLE:   cmd.accept = accept;
			ST_REDUCE: cmd.reduce = stat.lag_big;
			ST_READ:   cmd.rd_issue = 1'b1;
			ST_RANK:   cmd.rank_ld = 1'b1;
			ST_HREAD:  cmd.hist_rd = 1'b1;
			ST_HWRITE: begin
				cmd.hist_wr  = stat.out_free;
				cmd.emit_sym = stat.out_free;
			end
			ST_FREAD: begin
				cmd.hist_rd      = 1'b1;
				cmd.hist_sel_bin = 1'b1;
			end
			ST_FEMIT: begin
				cmd.emit_bin  = stat.out_free;
				cmd.clear_rec = stat.out_free && bin_last;
			end
			default: cmd = '0;
		endcase
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_REDUCE)
		else $error("accepted sample did not start processing");

	a_flush_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FREAD) |-> stat.last_rec)
		else $error("histogram flush outside a record end");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FEMIT) |-> bin_q < nb)
		else $error("bin number beyond the permutation count");

endmodule

`default_nettype wire
